FILE: hw/rtl/utit_pkg.sv
// Package for the unordered tuple id table.
// Holds default sizes, the sequencer state type and the sort schedule.
// No dependencies.
package utit_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_TUPLE_DEF   = 4;
    localparam int VERTEX_BITS_DEF = 32;

    // Vertex lanes carried by one transaction and width of each port field.
    localparam int IN_VERTS   = 4;
    localparam int VERT_W     = 32;
    localparam int COUNT_W    = 3;
    localparam int ENTRY_ID_W = 10;
    localparam int LANE_W     = 2;

    // Bubble sort over four lanes: six compare-exchange steps.
    localparam int SORT_STEPS  = 6;
    localparam int SORT_STEP_W = 3;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } utit_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_WAIT,
        ST_CMP,
        ST_STORE,
        ST_DONE
    } utit_state_t;

    // Lower lane of the pair handled at a given sort step.
    function automatic logic [LANE_W-1:0] sort_pair_lo(input logic [SORT_STEP_W-1:0] step);
        logic [LANE_W-1:0] lo;
        unique case (step)
            3'd0:    lo = 2'd0;
            3'd1:    lo = 2'd1;
            3'd2:    lo = 2'd2;
            3'd3:    lo = 2'd0;
            3'd4:    lo = 2'd1;
            default: lo = 2'd0;
        endcase
        return lo;
    endfunction

endpackage

FILE: hw/rtl/utit_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module utit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/unordered_tuple_id_table.sv
// Unordered tuple id table: top level with sequencer, sort lanes and key scan.
// Depends on utit_pkg and utit_ram.
//
// Gives each distinct unordered tuple of up to four vertex indices a dense id in
// order of first insertion; opcode 0 inserts, opcode 1 only looks up. One item
// is in work at a time and s_ready is low meanwhile. An accepted item sorts its
// indices with one shared compare-exchange unit, then scans the stored entries
// in id order through the single read port of the key memory: each key word
// compared, and each entry whose length differs, passes a wait and a compare
// state. A hit goes straight to the output. A miss is seen at the end of the
// scan, and a new key is then written one word at a time (only its length for
// an empty tuple). The done state loads the output register, waiting while an
// earlier result is not yet taken, and s_ready returns the cycle after. The
// scan over the stored entries sets the rate. No clearing pass is needed after
// reset.
module unordered_tuple_id_table #(
    parameter int TABLE_DEPTH = utit_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_TUPLE   = utit_pkg::MAX_TUPLE_DEF,
    parameter int VERTEX_BITS = utit_pkg::VERTEX_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [utit_pkg::COUNT_W-1:0]     s_vertex_count,
    input  logic [utit_pkg::VERT_W-1:0]      s_vertex_a,
    input  logic [utit_pkg::VERT_W-1:0]      s_vertex_b,
    input  logic [utit_pkg::VERT_W-1:0]      s_vertex_c,
    input  logic [utit_pkg::VERT_W-1:0]      s_vertex_d,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_found,
    output logic [utit_pkg::ENTRY_ID_W-1:0]  m_entry_id,
    output logic                             m_table_full
);

    import utit_pkg::*;

    localparam int KEY_W   = (VERTEX_BITS < VERT_W) ? VERTEX_BITS : VERT_W;
    localparam int LIM     = (MAX_TUPLE < IN_VERTS) ? MAX_TUPLE : IN_VERTS;
    localparam int WDEPTH  = TABLE_DEPTH * MAX_TUPLE;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int BW      = $clog2(WDEPTH + 1);
    localparam int LAW     = $clog2(TABLE_DEPTH);
    localparam int UW      = $clog2(TABLE_DEPTH + 1);

    utit_state_t state_reg, state_next;

    logic [KEY_W-1:0]       key_reg [IN_VERTS];
    logic [KEY_W-1:0]       key_next [IN_VERTS];
    logic [COUNT_W-1:0]     n_reg, n_next;
    logic                   op_reg, op_next;
    logic [SORT_STEP_W-1:0] step_reg, step_next;
    logic [LANE_W-1:0]      i_reg, i_next;
    logic [UW-1:0]          e_reg, e_next;
    logic [BW-1:0]          base_reg, base_next;
    logic [UW-1:0]          used_reg, used_next;
    logic                   res_found_reg, res_found_next;
    logic [UW-1:0]          res_id_reg, res_id_next;
    logic                   res_full_reg, res_full_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_found_reg, m_found_next;
    logic [UW-1:0]          m_id_reg, m_id_next;
    logic                   m_full_reg, m_full_next;

    logic                   accept;
    logic [COUNT_W-1:0]     n_sat;
    logic [LANE_W-1:0]      pair_lo, pair_hi;
    logic                   swap;
    logic                   sort_last;
    logic                   scan_end;
    logic                   table_is_full;
    logic                   last_word;
    logic                   len_match, word_match;
    logic                   cmp_hit, cmp_more;
    logic                   out_load;
    logic [BW-1:0]          word_addr;
    logic                   word_we, len_we;
    logic [KEY_W-1:0]       word_rdata;
    logic [COUNT_W-1:0]     len_rdata;
    logic [UW+ENTRY_ID_W-1:0] id_ext;

    // Shared condition terms
    assign accept        = s_valid && s_ready;
    assign n_sat         = (s_vertex_count > COUNT_W'(LIM)) ? COUNT_W'(LIM) : s_vertex_count;
    assign pair_lo       = sort_pair_lo(step_reg);
    assign pair_hi       = LANE_W'(pair_lo + 1'b1);
    assign swap          = ({1'b0, pair_hi} < n_reg) && (key_reg[pair_lo] > key_reg[pair_hi]);
    assign sort_last     = (step_reg == SORT_STEP_W'(SORT_STEPS - 1));
    assign scan_end      = (e_reg == used_reg);
    assign table_is_full = (used_reg == UW'(TABLE_DEPTH));
    assign last_word     = (n_reg == '0) || ({1'b0, i_reg} == COUNT_W'(n_reg - 1'b1));
    assign len_match     = (len_rdata == n_reg);
    assign word_match    = (word_rdata == key_reg[i_reg]);
    assign cmp_hit       = len_match && ((n_reg == '0) || (word_match && last_word));
    assign cmp_more      = len_match && (n_reg != '0) && word_match && !last_word;
    assign out_load      = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign word_addr     = BW'(base_reg + BW'(i_reg));

    utit_ram #(
        .WIDTH (KEY_W),
        .DEPTH (WDEPTH)
    ) u_key_words (
        .clk   (aclk),
        .we    (word_we),
        .waddr (word_addr[WAW-1:0]),
        .wdata (key_reg[i_reg]),
        .raddr (word_addr[WAW-1:0]),
        .rdata (word_rdata)
    );

    utit_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_lengths (
        .clk   (aclk),
        .we    (len_we),
        .waddr (used_reg[LAW-1:0]),
        .wdata (n_reg),
        .raddr (e_reg[LAW-1:0]),
        .rdata (len_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                if (sort_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                priority if (!scan_end) begin
                    state_next = ST_CMP;
                end else if (op_reg == OP_LOOKUP || table_is_full) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_CMP: begin
                state_next = cmp_hit ? ST_DONE : ST_WAIT;
            end
            ST_STORE: begin
                if (last_word) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory write strobes
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        word_we = (state_reg == ST_STORE) && ({1'b0, i_reg} < n_reg);
        len_we  = (state_reg == ST_STORE);
    end

    // Datapath next values
    always_comb begin
        key_next       = key_reg;
        n_next         = n_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        base_next      = base_reg;
        used_next      = used_reg;
        res_found_next = res_found_reg;
        res_id_next    = res_id_reg;
        res_full_next  = res_full_reg;
        m_valid_next   = m_valid_reg;
        m_found_next   = m_found_reg;
        m_id_next      = m_id_reg;
        m_full_next    = m_full_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    key_next[0] = s_vertex_a[KEY_W-1:0];
                    key_next[1] = s_vertex_b[KEY_W-1:0];
                    key_next[2] = s_vertex_c[KEY_W-1:0];
                    key_next[3] = s_vertex_d[KEY_W-1:0];
                    n_next      = n_sat;
                    op_next     = s_opcode;
                    step_next   = '0;
                end
            end
            ST_SORT: begin
                if (swap) begin
                    key_next[pair_lo] = key_reg[pair_hi];
                    key_next[pair_hi] = key_reg[pair_lo];
                end
                step_next = SORT_STEP_W'(step_reg + 1'b1);
                if (sort_last) begin
                    e_next    = '0;
                    base_next = '0;
                    i_next    = '0;
                end
            end
            ST_WAIT: begin
                if (scan_end) begin
                    // Miss: answer now unless a new key gets stored
                    res_found_next = 1'b0;
                    res_id_next    = '0;
                    res_full_next  = (op_reg == OP_INSERT) && table_is_full;
                    i_next         = '0;
                end
            end
            ST_CMP: begin
                priority if (cmp_hit) begin
                    res_found_next = 1'b1;
                    res_id_next    = e_reg;
                    res_full_next  = 1'b0;
                end else if (cmp_more) begin
                    i_next = LANE_W'(i_reg + 1'b1);
                end else begin
                    // Advance to the next stored entry
                    e_next    = UW'(e_reg + 1'b1);
                    base_next = BW'(base_reg + BW'(MAX_TUPLE));
                    i_next    = '0;
                end
            end
            ST_STORE: begin
                if (last_word) begin
                    res_found_next = 1'b0;
                    res_id_next    = used_reg;
                    res_full_next  = 1'b0;
                    used_next      = UW'(used_reg + 1'b1);
                end else begin
                    i_next = LANE_W'(i_reg + 1'b1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_id_next    = res_id_reg;
                    m_full_next  = res_full_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        n_reg         <= n_next;
        op_reg        <= op_next;
        step_reg      <= step_next;
        i_reg         <= i_next;
        e_reg         <= e_next;
        base_reg      <= base_next;
        res_found_reg <= res_found_next;
        res_id_reg    <= res_id_next;
        res_full_reg  <= res_full_next;
        m_found_reg   <= m_found_next;
        m_id_reg      <= m_id_next;
        m_full_reg    <= m_full_next;
    end

    assign id_ext       = {{ENTRY_ID_W{1'b0}}, m_id_reg};
    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_entry_id   = id_ext[ENTRY_ID_W-1:0];
    assign m_table_full = m_full_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_used_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg != $past(used_reg)) |-> (used_reg == UW'($past(used_reg) + 1'b1)))
        else $error("entry count changed by other than one");

    a_hit_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_found && m_table_full))
        else $error("result reports both found and table full");

    a_store_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        len_we |-> !table_is_full)
        else $error("key written into a full table");
`endif

endmodule

FILE: bench/tb_unordered_tuple_id_table.sv
// Testbench for unordered_tuple_id_table: directed and random insert/lookup
// traffic checked against a tuple id predictor kept inside the bench.
// Depends on utit_pkg and the unordered_tuple_id_table RTL.
module tb_unordered_tuple_id_table;
    timeunit 1ns;
    timeprecision 1ps;

    import utit_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int TUPLE_LIM    = (MAX_TUPLE_DEF < IN_VERTS) ? MAX_TUPLE_DEF : IN_VERTS;
    localparam int RANDOM_ITEMS = 500;
    // Slowest item: full scan of every word of every entry, plus both idle draws.
    localparam longint STEP_CYCLES = 9 + 2 * MAX_TUPLE_DEF * DEPTH + 2 * 7;
    localparam longint CYCLE_LIMIT = 4 * 2000 * STEP_CYCLES;
    localparam int DRAIN_CYCLES = 100;

    typedef logic [IN_VERTS-1:0][VERT_W-1:0] quad_t;

    typedef struct packed {
        logic                  found;
        logic [ENTRY_ID_W-1:0] id;
        logic                  full;
    } id_answer_t;

    localparam logic [7:0][VERT_W-1:0] VALUE_POOL = {
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000
    };

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_opcode       = 1'b0;
    logic [COUNT_W-1:0]    s_vertex_count = '0;
    logic [VERT_W-1:0]     s_vertex_a     = '0;
    logic [VERT_W-1:0]     s_vertex_b     = '0;
    logic [VERT_W-1:0]     s_vertex_c     = '0;
    logic [VERT_W-1:0]     s_vertex_d     = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_found;
    logic [ENTRY_ID_W-1:0] m_entry_id;
    logic                  m_table_full;

    // Predictor state: sorted keys by id, their lengths, and the next free id.
    quad_t              known_keys [DEPTH];
    logic [COUNT_W-1:0] known_lengths [DEPTH];
    int                 ids_issued = 0;
    id_answer_t         pending_ids [$];

    int     errors = 0;
    longint cycles = 0;
    bit     quiet  = 1'b0;

    unordered_tuple_id_table dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_vertex_count (s_vertex_count),
        .s_vertex_a     (s_vertex_a),
        .s_vertex_b     (s_vertex_b),
        .s_vertex_c     (s_vertex_c),
        .s_vertex_d     (s_vertex_d),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_entry_id     (m_entry_id),
        .m_table_full   (m_table_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic quad_t quad(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                                   logic [VERT_W-1:0] c, logic [VERT_W-1:0] d);
        return {d, c, b, a};
    endfunction

    // Ascending order on the first n lanes; clear the rest so keys compare whole.
    function automatic quad_t sorted_key(quad_t lanes, int n);
        quad_t           k;
        logic [VERT_W-1:0] t;
        int              i;
        int              j;
        k = lanes;
        for (i = 0; i < n - 1; i++)
            for (j = 0; j < n - 1 - i; j++)
                if (k[j] > k[j+1]) begin
                    t      = k[j];
                    k[j]   = k[j+1];
                    k[j+1] = t;
                end
        for (i = n; i < IN_VERTS; i++)
            k[i] = '0;
        return k;
    endfunction

    // Permute the first n lanes and fill the unused ones with noise.
    function automatic quad_t shuffled(quad_t lanes, int n);
        quad_t             q;
        logic [VERT_W-1:0] t;
        int                i;
        int                j;
        q = lanes;
        for (i = n - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
        end
        for (i = n; i < IN_VERTS; i++)
            q[i] = $urandom;
        return q;
    endfunction

    function automatic id_answer_t resolve_tuple_id(utit_op_t op, logic [COUNT_W-1:0] count,
                                                    quad_t lanes);
        int         n;
        int         e;
        bit         hit;
        quad_t      k;
        id_answer_t ans;
        n = count;
        if (n > TUPLE_LIM)
            n = TUPLE_LIM;
        k   = sorted_key(lanes, n);
        ans = '0;
        hit = 1'b0;
        for (e = 0; e < ids_issued && !hit; e++)
            if (known_lengths[e] == COUNT_W'(n) && known_keys[e] == k) begin
                hit       = 1'b1;
                ans.found = 1'b1;
                ans.id    = ENTRY_ID_W'(e);
            end
        if (!hit && op == OP_INSERT) begin
            if (ids_issued < DEPTH) begin
                known_keys[ids_issued]    = k;
                known_lengths[ids_issued] = COUNT_W'(n);
                ans.id                    = ENTRY_ID_W'(ids_issued);
                ids_issued++;
            end else begin
                ans.full = 1'b1;
            end
        end
        return ans;
    endfunction

    task automatic send_tuple(utit_op_t op, logic [COUNT_W-1:0] count, quad_t lanes);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_vertex_count <= count;
        s_vertex_a     <= lanes[0];
        s_vertex_b     <= lanes[1];
        s_vertex_c     <= lanes[2];
        s_vertex_d     <= lanes[3];
        do @(posedge aclk); while (!s_ready);
        pending_ids.push_back(resolve_tuple_id(op, count, lanes));
    endtask

    // Hold the sender off until every outstanding answer has been checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_ids.size() != 0);
    endtask

    task automatic test_empty_lookups();
        send_tuple(OP_LOOKUP, 3'd0, quad($urandom, $urandom, $urandom, $urandom));
        send_tuple(OP_LOOKUP, 3'd4, quad('1, '1, '1, '1));
        wait_for_results();
    endtask

    task automatic test_insert_and_match();
        send_tuple(OP_INSERT, 3'd0, quad($urandom, $urandom, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd0, quad($urandom, $urandom, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd1, quad(32'h0, $urandom, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd1, quad('1, $urandom, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd3, quad(32'd3, 32'd1, 32'd2, $urandom));
        send_tuple(OP_INSERT, 3'd3, quad(32'd2, 32'd3, 32'd1, $urandom));
        send_tuple(OP_LOOKUP, 3'd3, quad(32'd1, 32'd3, 32'd2, $urandom));
        // same leading lanes, shorter count: must miss
        send_tuple(OP_LOOKUP, 3'd2, quad(32'd1, 32'd2, 32'd3, $urandom));
        send_tuple(OP_INSERT, 3'd2, quad(32'd2, 32'd1, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd4, quad('1, 32'h0, '1, 32'h0));
        send_tuple(OP_INSERT, 3'd4, quad(32'h0, 32'h0, '1, '1));
        send_tuple(OP_LOOKUP, 3'd4, quad(32'h0, '1, '1, '1));
        send_tuple(OP_INSERT, 3'd4, quad(32'd5, 32'd5, 32'd5, 32'd5));
        send_tuple(OP_INSERT, 3'd2, quad(32'hAAAA_AAAA, 32'h5555_5555, $urandom, $urandom));
        send_tuple(OP_LOOKUP, 3'd2, quad(32'h5555_5555, 32'hAAAA_AAAA, $urandom, $urandom));
        wait_for_results();
    endtask

    task automatic test_count_saturation();
        send_tuple(OP_INSERT, 3'd7, quad(32'd9, 32'd8, 32'd7, 32'd6));
        send_tuple(OP_LOOKUP, 3'd4, quad(32'd6, 32'd7, 32'd8, 32'd9));
        send_tuple(OP_LOOKUP, 3'd5, quad(32'd8, 32'd6, 32'd9, 32'd7));
        send_tuple(OP_INSERT, 3'd6, quad('1, 32'h0, '1, 32'h0));
        send_tuple(OP_LOOKUP, 3'd3, quad(32'd6, 32'd7, 32'd8, $urandom));
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        quad_t              lanes;
        logic [COUNT_W-1:0] count;
        utit_op_t           op;
        int                 item;
        int                 pick;
        int                 e;
        int                 n;
        int                 sel;
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            op   = ($urandom_range(0, 99) < 60) ? OP_INSERT : OP_LOOKUP;
            pick = $urandom_range(0, 99);
            if (pick < 55 && ids_issued > 0) begin
                // revisit a stored tuple in a new order
                e     = $urandom_range(0, ids_issued - 1);
                n     = known_lengths[e];
                lanes = shuffled(known_keys[e], n);
                count = COUNT_W'(n);
                if (n == TUPLE_LIM && $urandom_range(0, 3) == 0)
                    count = COUNT_W'($urandom_range(n, 7));
                if (pick >= 40) begin
                    // near miss: one flipped bit, or one lane fewer (one more for an empty tuple)
                    if (n > 0 && $urandom_range(0, 1) == 1) begin
                        sel = $urandom_range(0, n - 1);
                        lanes[sel][$urandom_range(0, VERT_W - 1)] ^= 1'b1;
                    end else begin
                        count = (n == 0) ? COUNT_W'(1) : COUNT_W'(n - 1);
                    end
                end
            end else if (pick < 80) begin
                count = COUNT_W'($urandom_range(0, 7));
                for (n = 0; n < IN_VERTS; n++)
                    lanes[n] = VALUE_POOL[$urandom_range(0, 7)];
            end else begin
                count = COUNT_W'($urandom_range(0, 7));
                lanes = quad($urandom, $urandom, $urandom, $urandom);
            end
            send_tuple(op, count, lanes);
        end
        quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_full_table();
        int e;
        while (ids_issued < DEPTH)
            send_tuple(OP_INSERT, COUNT_W'($urandom_range(1, 4)),
                       quad($urandom, $urandom, $urandom, $urandom));
        wait_for_results();
        send_tuple(OP_INSERT, 3'd3, quad($urandom, $urandom, $urandom, $urandom));
        e = DEPTH - 1;
        send_tuple(OP_INSERT, known_lengths[e], shuffled(known_keys[e], known_lengths[e]));
        send_tuple(OP_INSERT, 3'd0, quad($urandom, $urandom, $urandom, $urandom));
        send_tuple(OP_LOOKUP, 3'd4, quad($urandom, $urandom, $urandom, $urandom));
        e = $urandom_range(0, DEPTH - 1);
        send_tuple(OP_LOOKUP, known_lengths[e], shuffled(known_keys[e], known_lengths[e]));
        send_tuple(OP_INSERT, 3'd7, quad($urandom, $urandom, $urandom, $urandom));
        send_tuple(OP_INSERT, 3'd1, quad('1, $urandom, $urandom, $urandom));
        wait_for_results();
    endtask

    initial begin : result_ready
        int stall;
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : check_results
        id_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ids.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual found %0d id %0d full %0d",
                         $time, m_found, m_entry_id, m_table_full);
                errors++;
            end else begin
                want = pending_ids.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t: found mismatch, expected %0d, actual %0d",
                             $time, want.found, m_found);
                    errors++;
                end
                if (m_entry_id !== want.id) begin
                    $display("%0t: entry_id mismatch, expected %0d, actual %0d",
                             $time, want.id, m_entry_id);
                    errors++;
                end
                if (m_table_full !== want.full) begin
                    $display("%0t: table_full mismatch, expected %0d, actual %0d",
                             $time, want.full, m_table_full);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d answers outstanding", $time, pending_ids.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_lookups();
        test_insert_and_match();
        test_count_saturation();
        test_random_traffic();
        test_full_table();
        wait_for_results();
        // leave room for a stray transaction to show up
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
